[rtl/core/imhq_pkg.sv]
// Package for the indexed max-heap queue: widths, command and status codes.
// No dependencies.
package imhq_pkg;
	localparam int CAPACITY_DEF = 256;
	localparam int KEY_COUNT_DEF = 256;
	localparam int PRIORITY_BITS_DEF = 16;
	localparam int CMD_W = 2;
	localparam int KEY_W = 8;
	localparam int AMT_W = 16;
	localparam int STATUS_W = 3;
	localparam int STAMP_W = 32;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RAISE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key_id;
		logic [AMT_W-1:0] amount;
	} cmd_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0] top_key;
	} rsp_item_t;
endpackage

[rtl/core/imhq_if.sv]
// Valid/ready channel interfaces for command and response items.
// Depends on imhq_pkg.
interface imhq_cmd_if (input logic clk);
	logic valid;
	logic ready;
	imhq_pkg::cmd_item_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface imhq_rsp_if (input logic clk);
	logic valid;
	logic ready;
	imhq_pkg::rsp_item_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/core/indexed_max_heap_queue.sv]
// Indexed max-heap priority queue, top level with heap sequencer and memories.
// Depends on imhq_pkg and the channel interfaces in imhq_if.
//
//  channel  dir  payload               handshake
//  cmd      in   cmd, key_id, amount   valid/ready
//  rsp      out  status, top_key       valid/ready
//
// One command at a time; query and rejected ones only read and decode. Insert
// sifts up, comparing with the parent per level; raise first reads its own
// slot; remove reads the last slot and sifts down, reading both children per
// level, or else up. Slot memory has one read and one write port. Reset clears
// presence bits at once. The response waits in an output register until taken.
module indexed_max_heap_queue #(
	parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
	parameter int KEY_COUNT = imhq_pkg::KEY_COUNT_DEF,
	parameter int PRIORITY_BITS = imhq_pkg::PRIORITY_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	imhq_cmd_if.sink cmd,
	imhq_rsp_if.source rsp
);
	import imhq_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int KW = $clog2(KEY_COUNT);
	localparam int CW = SW + 1;
	localparam int EW = PRIORITY_BITS + STAMP_W + KEY_W;
	localparam int SUMW = ((PRIORITY_BITS > AMT_W) ? PRIORITY_BITS : AMT_W) + 1;
	localparam logic [PRIORITY_BITS-1:0] PMAX = '1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_KEYRD = 4'd1;
	localparam logic [3:0] S_DEC = 4'd2;
	localparam logic [3:0] S_UPRD = 4'd3;
	localparam logic [3:0] S_UPCMP = 4'd4;
	localparam logic [3:0] S_RMRD = 4'd5;
	localparam logic [3:0] S_RMWR = 4'd6;
	localparam logic [3:0] S_DNL = 4'd7;
	localparam logic [3:0] S_DNR = 4'd8;
	localparam logic [3:0] S_DNCMP = 4'd9;
	localparam logic [3:0] S_RSP = 4'd10;
	localparam logic [3:0] S_CURRD = 4'd11;

	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [STAMP_W-1:0] stamp;
		logic [KEY_W-1:0] key;
	} entry_t;

	// Slot memory and key position memory
	entry_t slot_mem [CAPACITY];
	logic [SW-1:0] pos_mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] present_q;

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic [STAMP_W-1:0] stamp_q;
	cmd_item_t req_q;
	rsp_item_t rsp_q;
	logic rsp_valid_q;
	logic [SW-1:0] i_q, best_q;
	entry_t cur_q, other_q, best_e_q;
	logic down_q;

	// memory ports
	logic s_we, s_re;
	logic [SW-1:0] s_waddr, s_raddr;
	entry_t s_wdata, s_rdata_q;
	logic p_we;
	logic [KW-1:0] p_waddr;
	logic [SW-1:0] p_wdata, p_rdata_q;

	always_ff @(posedge clk) begin
		if (s_we) slot_mem[s_waddr] <= s_wdata;
		if (s_re) s_rdata_q <= slot_mem[s_raddr];
		if (p_we) pos_mem[p_waddr] <= p_wdata;
		p_rdata_q <= pos_mem[req_q.key_id[KW-1:0]];
	end

	function automatic logic below(entry_t a, entry_t b);
		if (a.prio != b.prio) return a.prio < b.prio;
		return a.stamp > b.stamp;
	endfunction

	logic key_ok;
	logic [SUMW-1:0] sum;
	logic [PRIORITY_BITS-1:0] raised_prio;
	logic [SW-1:0] parent, lchild, rchild;
	logic [CW:0] l_ext, r_ext;
	assign key_ok = ({1'b0, req_q.key_id} < (KEY_W+1)'(KEY_COUNT));
	assign sum = SUMW'(s_rdata_q.prio) + SUMW'(req_q.amount);
	assign raised_prio = (sum > SUMW'(PMAX)) ? PMAX : sum[PRIORITY_BITS-1:0];
	assign parent = (i_q - SW'(1)) >> 1;
	assign l_ext = {i_q, 1'b0} + (CW+1)'(1);
	assign r_ext = {i_q, 1'b0} + (CW+1)'(2);
	assign lchild = l_ext[SW-1:0];
	assign rchild = r_ext[SW-1:0];

	logic r_win;
	logic [SW-1:0] dn_idx;
	entry_t dn_e;
	assign r_win = (r_ext < (CW+1)'(count_q)) && below(best_e_q, s_rdata_q);
	assign dn_idx = r_win ? rchild : best_q;
	assign dn_e = r_win ? s_rdata_q : best_e_q;

	logic [AMT_W:0] amt_ext;
	logic [PRIORITY_BITS-1:0] ins_prio;
	assign amt_ext = {1'b0, req_q.amount};
	assign ins_prio = (amt_ext > (AMT_W+1)'(PMAX)) ? PMAX : PRIORITY_BITS'(req_q.amount);

	always_comb begin
		s_we = 1'b0; s_re = 1'b0; s_waddr = i_q; s_raddr = i_q; s_wdata = cur_q;
		p_we = 1'b0; p_waddr = cur_q.key[KW-1:0]; p_wdata = i_q;
		case (state_q)
			S_IDLE: begin s_re = 1'b1; s_raddr = '0; end
			S_UPRD: begin s_re = 1'b1; s_raddr = parent; end
			S_UPCMP: begin
				s_we = 1'b1; p_we = 1'b1;
				if (i_q != '0 && below(s_rdata_q, cur_q)) begin
					s_wdata = s_rdata_q; p_waddr = s_rdata_q.key[KW-1:0];
				end
			end
			S_CURRD: begin s_re = 1'b1; s_raddr = i_q; end
			S_RMRD: begin s_re = 1'b1; s_raddr = SW'(count_q); end
			S_DNL: begin s_re = 1'b1; s_raddr = lchild; end
			S_DNR: begin s_re = 1'b1; s_raddr = rchild; end
			S_DNCMP: begin
				s_we = 1'b1; p_we = 1'b1;
				if (dn_idx != i_q) begin
					s_wdata = dn_e; p_waddr = dn_e.key[KW-1:0];
				end
			end
			default: ;
		endcase
	end

	assign cmd.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			stamp_q <= '0;
			present_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.valid && cmd.ready) begin
					req_q <= cmd.data;
					stamp_q <= stamp_q + STAMP_W'(1);
					cur_q.stamp <= stamp_q;
					rsp_q <= '{status: ST_OK, top_key: '0};
					state_q <= S_KEYRD;
				end
				S_KEYRD: state_q <= S_DEC;
				S_DEC: begin
					state_q <= S_RSP;
					if (req_q.cmd == CMD_QUERY) begin
						if (count_q == '0) rsp_q.status <= ST_EMPTY;
						else rsp_q.top_key <= s_rdata_q.key;
					end else if (req_q.cmd == CMD_RAISE && req_q.amount == '0) begin
					end else if (!key_ok) rsp_q.status <= ST_NOT_FOUND;
					else if (req_q.cmd == CMD_INSERT) begin
						if (present_q[req_q.key_id[KW-1:0]]) rsp_q.status <= ST_PRESENT;
						else if (count_q >= CW'(CAPACITY)) rsp_q.status <= ST_FULL;
						else begin
							present_q[req_q.key_id[KW-1:0]] <= 1'b1;
							count_q <= count_q + CW'(1);
							i_q <= SW'(count_q);
							cur_q.prio <= ins_prio;
							cur_q.key <= req_q.key_id;
							state_q <= S_UPRD;
						end
					end else if (!present_q[req_q.key_id[KW-1:0]])
						rsp_q.status <= ST_NOT_FOUND;
					else begin
						i_q <= p_rdata_q;
						state_q <= (req_q.cmd == CMD_RAISE) ? S_CURRD : S_RMRD;
						if (req_q.cmd == CMD_REMOVE) begin
							present_q[req_q.key_id[KW-1:0]] <= 1'b0;
							count_q <= count_q - CW'(1);
						end
					end
				end
				S_CURRD: state_q <= S_RMWR;
				S_RMRD: state_q <= S_RMWR;
				S_RMWR: begin
					// raise: cur from own slot; remove: cur from last slot
					if (req_q.cmd == CMD_RAISE) begin
						cur_q <= '{prio: raised_prio, stamp: s_rdata_q.stamp,
							key: s_rdata_q.key};
						state_q <= S_UPRD;
					end else begin
						cur_q <= s_rdata_q;
						if ({1'b0, i_q} < count_q) begin
							down_q <= 1'b1;
							state_q <= S_DNL;
						end else state_q <= S_RSP;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (i_q != '0 && below(s_rdata_q, cur_q)) begin
						i_q <= parent;
						state_q <= S_UPRD;
					end else state_q <= S_RSP;
				end
				S_DNL: begin
					best_q <= i_q; best_e_q <= cur_q;
					state_q <= S_DNR;
				end
				S_DNR: begin
					if (l_ext < (CW+1)'(count_q) && below(best_e_q, s_rdata_q)) begin
						best_q <= lchild; best_e_q <= s_rdata_q;
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (dn_idx != i_q) begin
						i_q <= dn_idx;
						state_q <= S_DNL;
						down_q <= 1'b0;
					end else if (down_q) begin
						// no move at all: try sifting up instead
						state_q <= S_UPRD;
					end else state_q <= S_RSP;
				end
				S_RSP: begin
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[test/imhq_heap_checker.sv]
// Response checker for the indexed max-heap queue: keeps its own heap copy.
// Depends on imhq_pkg and the channel interfaces in imhq_if.
`timescale 1ns / 1ps
module imhq_heap_checker (
	input logic clk,
	input logic arst_n,
	imhq_cmd_if cmd,
	imhq_rsp_if rsp,
	output int fail_count,
	output int pending
);
	import imhq_pkg::*;
	localparam int SLOTS = CAPACITY_DEF;
	localparam int KEYS = KEY_COUNT_DEF;
	localparam logic [31:0] PRIO_TOP = 32'hFFFF_FFFF >> (32 - PRIORITY_BITS_DEF);

	logic [31:0] hp_prio [SLOTS];
	logic [31:0] hp_stamp [SLOTS];
	logic [KEY_W-1:0] hp_key [SLOTS];
	int key_slot [KEYS];
	bit key_held [KEYS];
	int used;
	logic [31:0] stamp_ctr;
	rsp_item_t awaited [$];

	function automatic bit lower(int a, int b);
		if (hp_prio[a] != hp_prio[b])
			return hp_prio[a] < hp_prio[b];
		return hp_stamp[a] > hp_stamp[b];
	endfunction

	function automatic void exchange(int a, int b);
		logic [31:0] p, s;
		logic [KEY_W-1:0] k;
		p = hp_prio[a]; hp_prio[a] = hp_prio[b]; hp_prio[b] = p;
		s = hp_stamp[a]; hp_stamp[a] = hp_stamp[b]; hp_stamp[b] = s;
		k = hp_key[a]; hp_key[a] = hp_key[b]; hp_key[b] = k;
		key_slot[hp_key[a]] = a;
		key_slot[hp_key[b]] = b;
	endfunction

	function automatic void sift_to_root(int i);
		while (i > 0 && lower((i - 1) / 2, i)) begin
			exchange(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
	endfunction

	function automatic void sift_to_leaf(int i);
		int best;
		while (i < used) begin
			best = i;
			if (2 * i + 1 < used && lower(best, 2 * i + 1))
				best = 2 * i + 1;
			if (2 * i + 2 < used && lower(best, 2 * i + 2))
				best = 2 * i + 2;
			if (best == i)
				break;
			exchange(i, best);
			i = best;
		end
	endfunction

	function automatic rsp_item_t apply_command(cmd_item_t c);
		rsp_item_t r;
		int i;
		logic [32:0] sum;
		r.status = ST_OK;
		r.top_key = '0;
		stamp_ctr = stamp_ctr + 1;
		if (c.cmd == CMD_QUERY) begin
			if (used == 0)
				r.status = ST_EMPTY;
			else
				r.top_key = hp_key[0];
		end else if (c.cmd == CMD_RAISE && c.amount == 0) begin
			r.status = ST_OK;
		end else if (c.cmd == CMD_INSERT) begin
			if (key_held[c.key_id])
				r.status = ST_PRESENT;
			else if (used >= SLOTS)
				r.status = ST_FULL;
			else begin
				i = used;
				hp_prio[i] = (c.amount > PRIO_TOP) ? PRIO_TOP : 32'(c.amount);
				hp_stamp[i] = stamp_ctr - 1;
				hp_key[i] = c.key_id;
				key_slot[c.key_id] = i;
				key_held[c.key_id] = 1;
				used++;
				sift_to_root(i);
			end
		end else if (!key_held[c.key_id]) begin
			r.status = ST_NOT_FOUND;
		end else if (c.cmd == CMD_RAISE) begin
			i = key_slot[c.key_id];
			sum = hp_prio[i] + c.amount;
			hp_prio[i] = (sum > PRIO_TOP) ? PRIO_TOP : sum[31:0];
			sift_to_root(i);
		end else begin
			i = key_slot[c.key_id];
			exchange(i, used - 1);
			key_held[c.key_id] = 0;
			used--;
			if (i < used) begin
				sift_to_leaf(i);
				sift_to_root(i);
			end
		end
		return r;
	endfunction

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			used = 0;
			stamp_ctr = '0;
			fail_count = 0;
			awaited.delete();
			foreach (key_held[k])
				key_held[k] = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected item: status %0d top %0d",
							rsp.data.status, rsp.data.top_key);
				end else begin
					want = awaited.pop_front();
					if (want.status !== rsp.data.status || want.top_key !== rsp.data.top_key) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected status %0d top %0d, got %0d %0d",
								want.status, want.top_key, rsp.data.status, rsp.data.top_key);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				awaited.insert(awaited.size(), apply_command(cmd.data));
		end
	end
endmodule

[test/testbench.sv]
// Top of the indexed max-heap queue testbench: clock, reset, stimulus, verdict.
// Depends on imhq_pkg, imhq_if, imhq_heap_checker and the block.
`timescale 1ns / 1ps
module testbench;
	import imhq_pkg::*;
	logic clk;
	logic arst_n;
	int fail_count, pending;
	int send_idle, recv_idle;
	imhq_cmd_if cmd (clk);
	imhq_rsp_if rsp (clk);

	indexed_max_heap_queue DUT (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));
	imhq_heap_checker checker_i (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [AMT_W-1:0] a);
		while ($urandom_range(99) < send_idle) begin
			cmd.valid <= 0;
			@(posedge clk);
		end
		cmd.valid <= 1;
		cmd.data <= '{cmd: c, key_id: k, amount: a};
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
	endtask

	task automatic random_phase(int n, int keyspan);
		int r;
		logic [AMT_W-1:0] a;
		repeat (n) begin
			r = $urandom_range(99);
			a = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 65500))
				: ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
			if (r < 45)
				send(CMD_INSERT, 8'($urandom_range(keyspan)), a);
			else if (r < 60)
				send(CMD_RAISE, 8'($urandom_range(keyspan)), a);
			else if (r < 80)
				send(CMD_REMOVE, 8'($urandom_range(keyspan)), a);
			else
				send(CMD_QUERY, 8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		cmd.valid = 0;
		cmd.data = '0;
		send_idle = 14;
		recv_idle = 59;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(CMD_QUERY, 8'hFF, 16'hFFFF);
		send(CMD_REMOVE, 8'd0, 16'd0);
		send(CMD_RAISE, 8'd3, 16'd0);
		send(CMD_RAISE, 8'd3, 16'd5);
		send(CMD_INSERT, 8'd0, 16'd0);
		send(CMD_INSERT, 8'hFF, 16'hFFFF);
		send(CMD_INSERT, 8'h10, 16'hFFFF);
		send(CMD_INSERT, 8'h10, 16'd1);
		send(CMD_QUERY, 8'd0, 16'd0);
		send(CMD_RAISE, 8'd0, 16'hFFFF);
		send(CMD_QUERY, 8'd0, 16'd0);
		send(CMD_REMOVE, 8'hFF, 16'd0);
		send(CMD_REMOVE, 8'hFF, 16'd0);
		send(CMD_QUERY, 8'd0, 16'd0);
		for (int k = 0; k < 256; k++)
			send(CMD_INSERT, 8'(k), 16'($urandom_range(40)));
		send(CMD_INSERT, 8'hFF, 16'd1);
		send(CMD_QUERY, 8'd0, 16'd0);
		for (int k = 0; k < 256; k += 2)
			send(CMD_REMOVE, 8'(k), 16'd0);
		random_phase(450, 255);
		send_idle = 59;
		recv_idle = 14;
		random_phase(450, 40);
		send_idle = 0;
		recv_idle = 0;
		random_phase(450, 255);
		cmd.valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[sim.f]
rtl/core/imhq_pkg.sv
rtl/core/imhq_if.sv
rtl/core/indexed_max_heap_queue.sv
test/imhq_heap_checker.sv
test/testbench.sv
